// File: design/ttq_pkg.sv
// Shared types, constants and helpers for the timer event priority queue.
// No dependencies; every other file imports this package.
`default_nettype none

package ttq_pkg;

   localparam int DEPTH       = 16;
   localparam int MAX_RESULTS = 16;
   localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int NUM_W       = $clog2(MAX_RESULTS + 1);

   localparam logic       CMD_ADD   = 1'b0;
   localparam logic       CMD_TICK  = 1'b1;
   localparam logic [1:0] ST_ACCEPT = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_FIRED  = 2'd2;

   typedef struct packed {
      logic        cmd;
      logic [7:0]  task_id;
      logic [15:0] delay;
      logic        is_recurring;
      logic [15:0] period;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  fired_id;
      logic [31:0] fire_time;
      logic        last;
   } rsp_type;

   // Broadcast from the controller to every cell
   typedef struct packed {
      logic             add_en;
      logic             fire_en;
      logic             done_clr;
      logic [IDX_W-1:0] idx;
      logic [31:0]      deadline;
      logic [7:0]       id;
      logic             rec;
      logic [15:0]      per;
      logic [31:0]      now;
   } cell_op_type;

   // Scan value handed from cell to cell
   typedef struct packed {
      logic             due_found;
      logic [31:0]      due_dl;
      logic [IDX_W-1:0] due_idx;
      logic [7:0]       due_id;
      logic             due_rec;
      logic [15:0]      due_per;
      logic             free_found;
      logic [IDX_W-1:0] free_idx;
   } carry_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FLUSH
   } state_type;

   // Add with saturation at the counter maximum
   function automatic logic [31:0] sat_add(input logic [31:0] base, input logic [15:0] inc);
      logic [32:0] sum;
      sum = {1'b0, base} + {17'b0, inc};
      return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   endfunction

endpackage

`default_nettype wire

// File: design/timer_event_priority_queue.sv
// Timer event priority queue: a row of DEPTH slot cells scanned as a chain.
// An add answers after one scan. A tick fires one due slot per scan, earliest first,
// and shows each firing one scan later; at the MAX_RESULTS limit the last one comes
// from the flush state. busy covers the whole request: it falls as the final
// response shows, and the next request can be taken then.
// No stall; sync reset clears the counter and valid bits.
`default_nettype none

module timer_event_priority_queue (
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   input  ttq_pkg::req_type  req_item,
   output logic              busy,
   output logic              rsp_strobe,
   output ttq_pkg::rsp_type  rsp_item
);
   import ttq_pkg::*;

   carry_type   chain [DEPTH+1];
   cell_op_type op;

   // Seed the head of the scan chain with an empty value
   assign chain[0] = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      ttq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_idx  (IDX_W'(i)),
         .op        (op),
         .carry_in  (chain[i]),
         .carry_out (chain[i+1])
      );
   end

   ttq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_item   (req_item),
      .busy       (busy),
      .carry      (chain[DEPTH]),
      .op         (op),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

`default_nettype wire

// File: design/ttq_cell.sv
// One timer slot of the queue plus its stage of the scan chain.
// Depends on ttq_pkg.
`default_nettype none

module ttq_cell (
   input  wire                          clock,
   input  wire                          reset,
   input  wire  [ttq_pkg::IDX_W-1:0]    cell_idx,
   input  ttq_pkg::cell_op_type         op,
   input  ttq_pkg::carry_type           carry_in,
   output ttq_pkg::carry_type           carry_out
);
   import ttq_pkg::*;

   logic             valid_ff, valid_in;
   logic             done_ff, done_in;
   logic [31:0]      deadline_ff, deadline_in;
   logic [7:0]       id_ff, id_in;
   logic             rec_ff, rec_in;
   logic [15:0]      per_ff, per_in;
   carry_type        carry_ff, carry_in_next;
   logic             hit;
   logic             due;

   assign hit = (op.idx == cell_idx);
   assign due = valid_ff && !done_ff && (deadline_ff <= op.now);

   // Apply add, fire and done-clear requests to this slot
   always_comb begin
      valid_in    = valid_ff;
      done_in     = done_ff;
      deadline_in = deadline_ff;
      id_in       = id_ff;
      rec_in      = rec_ff;
      per_in      = per_ff;
      if (op.done_clr) begin
         done_in = 1'b0;
      end
      if (op.add_en && hit) begin
         valid_in    = 1'b1;
         deadline_in = op.deadline;
         id_in       = op.id;
         rec_in      = op.rec;
         per_in      = op.per;
      end
      if (op.fire_en && hit) begin
         done_in = 1'b1;
         if (rec_ff) begin
            deadline_in = op.deadline;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   // Merge this slot into the scan value: earliest due, lowest free
   always_comb begin
      carry_in_next = carry_in;
      if (due && (!carry_in.due_found || deadline_ff < carry_in.due_dl)) begin
         carry_in_next.due_found = 1'b1;
         carry_in_next.due_dl    = deadline_ff;
         carry_in_next.due_idx   = cell_idx;
         carry_in_next.due_id    = id_ff;
         carry_in_next.due_rec   = rec_ff;
         carry_in_next.due_per   = per_ff;
      end
      if (!carry_in.free_found && !valid_ff) begin
         carry_in_next.free_found = 1'b1;
         carry_in_next.free_idx   = cell_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         done_ff  <= 1'b0;
         carry_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         done_ff  <= done_in;
         carry_ff <= carry_in_next;
      end
   end

   always_ff @(posedge clock) begin
      deadline_ff <= deadline_in;
      id_ff       <= id_in;
      rec_ff      <= rec_in;
      per_ff      <= per_in;
   end

   assign carry_out = carry_ff;

endmodule

`default_nettype wire

// File: design/ttq_ctrl.sv
// Command sequencer: tick counter, scan timing, firing and response staging.
// Depends on ttq_pkg.
`default_nettype none

module ttq_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   input  ttq_pkg::req_type      req_item,
   output logic                  busy,
   input  ttq_pkg::carry_type    carry,
   output ttq_pkg::cell_op_type  op,
   output logic                  rsp_strobe,
   output ttq_pkg::rsp_type      rsp_item
);
   import ttq_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [31:0]      now_ff, now_in;
   req_type          req_ff, req_in;
   logic             pend_ff, pend_in;
   logic [7:0]       pend_id_ff, pend_id_in;
   logic             strobe_ff, strobe_in;
   rsp_type          rsp_ff, rsp_in;
   logic             scan_end;

   assign scan_end = (cnt_ff == CNT_W'(DEPTH));
   assign busy     = (state_ff != S_IDLE);

   // Next state, cell requests and responses
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      num_in     = num_ff;
      now_in     = now_ff;
      req_in     = req_ff;
      pend_in    = pend_ff;
      pend_id_in = pend_id_ff;
      strobe_in  = 1'b0;
      rsp_in     = rsp_ff;
      op         = '0;
      op.now     = now_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_item;
               cnt_in   = '0;
               num_in   = '0;
               pend_in  = 1'b0;
               state_in = S_SCAN;
               if (req_item.cmd == CMD_TICK) begin
                  now_in      = now_ff + 32'd1;
                  op.done_clr = 1'b1;
               end
            end
         end
         S_SCAN: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (scan_end) begin
               cnt_in = '0;
               if (req_ff.cmd == CMD_ADD) begin
                  // Store into the lowest free slot or reject
                  strobe_in          = 1'b1;
                  rsp_in.status      = carry.free_found ? ST_ACCEPT : ST_FULL;
                  rsp_in.fired_id    = req_ff.task_id;
                  rsp_in.fire_time   = now_ff;
                  rsp_in.last        = 1'b1;
                  op.add_en          = carry.free_found;
                  op.idx             = carry.free_idx;
                  op.deadline        = sat_add(now_ff, req_ff.delay);
                  op.id              = req_ff.task_id;
                  op.rec             = req_ff.is_recurring;
                  op.per             = req_ff.period;
                  state_in           = S_IDLE;
               end else if (carry.due_found) begin
                  // Fire the earliest due slot; release the one held before
                  op.fire_en  = 1'b1;
                  op.idx      = carry.due_idx;
                  op.deadline = sat_add(now_ff, carry.due_per);
                  num_in      = num_ff + NUM_W'(1);
                  if (pend_ff) begin
                     strobe_in        = 1'b1;
                     rsp_in.status    = ST_FIRED;
                     rsp_in.fired_id  = pend_id_ff;
                     rsp_in.fire_time = now_ff;
                     rsp_in.last      = 1'b0;
                  end
                  pend_in    = 1'b1;
                  pend_id_in = carry.due_id;
                  if (num_ff + NUM_W'(1) == NUM_W'(MAX_RESULTS)) begin
                     state_in = S_FLUSH;
                  end
               end else begin
                  // Nothing more is due: close out with the held firing
                  if (pend_ff) begin
                     strobe_in        = 1'b1;
                     rsp_in.status    = ST_FIRED;
                     rsp_in.fired_id  = pend_id_ff;
                     rsp_in.fire_time = now_ff;
                     rsp_in.last      = 1'b1;
                  end
                  pend_in  = 1'b0;
                  state_in = S_IDLE;
               end
            end
         end
         S_FLUSH: begin
            strobe_in        = 1'b1;
            rsp_in.status    = ST_FIRED;
            rsp_in.fired_id  = pend_id_ff;
            rsp_in.fire_time = now_ff;
            rsp_in.last      = 1'b1;
            pend_in          = 1'b0;
            state_in         = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cnt_ff    <= '0;
         num_ff    <= '0;
         now_ff    <= '0;
         pend_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         num_ff    <= num_in;
         now_ff    <= now_in;
         pend_ff   <= pend_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      pend_id_ff <= pend_id_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

`default_nettype wire

// File: design/ttq_checker.sv
// Port-level checks for the timer event priority queue, bound to the top level.
// Depends on ttq_pkg and timer_event_priority_queue.
`default_nettype none

module ttq_checker (
   input wire               clock,
   input wire               reset,
   input wire               start,
   input wire               busy,
   input wire               rsp_strobe,
   input ttq_pkg::rsp_type  rsp_item
);
   import ttq_pkg::*;

   // A scan always runs before any response to a fresh request
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_strobe)
      else $error("response right after request acceptance");

   // Add responses are always final
   a_add_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.status != ST_FIRED) |-> rsp_item.last)
      else $error("add response without last");

   // More responses pending means the block is still working
   a_more_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_item.last) |-> busy)
      else $error("non-final response while idle");

   // The final response leaves the block free for the next request
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.last) |-> !busy)
      else $error("still busy on final response");

endmodule

bind timer_event_priority_queue ttq_checker u_ttq_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);

`default_nettype wire

// File: bench/tb_timer_event_priority_queue.sv
// Self-checking bench for timer_event_priority_queue: directed and random adds and ticks.
// Predicts every response from its own deadline-queue model; depends on ttq_pkg and the DUT.
module tb_timer_event_priority_queue;
   import ttq_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int TAIL_CYCLES = 2 * DEPTH + 8;
   localparam int RANDOM_PER_PHASE = 112;

   // Timer queue scoreboard: owns a copy of the queue state and the responses still owed
   class timer_queue_scoreboard;
      bit [31:0] now_ticks;
      bit        occupied[DEPTH];
      bit [31:0] deadline[DEPTH];
      bit [7:0]  ident[DEPTH];
      bit        recurring[DEPTH];
      bit [15:0] interval[DEPTH];
      rsp_type   owed_responses[$];
      int        errors;

      // Clamp the sum at the counter maximum
      function bit [31:0] clamp_sum(bit [31:0] base, bit [15:0] inc);
         if (base > 32'hFFFF_FFFF - {16'd0, inc})
            return 32'hFFFF_FFFF;
         return base + {16'd0, inc};
      endfunction

      function int pending();
         return owed_responses.size();
      endfunction

      function int resident_recurring();
         int count;
         count = 0;
         for (int s = 0; s < DEPTH; s++)
            if (occupied[s] && recurring[s]) count++;
         return count;
      endfunction

      // Apply one accepted request and queue the responses it causes
      function void note_request(req_type r);
         rsp_type resp;
         bit      fired[DEPTH];
         int      slot;
         int      best;
         int      n;
         if (r.cmd == CMD_ADD) begin
            slot = -1;
            for (int s = DEPTH - 1; s >= 0; s--)
               if (!occupied[s]) slot = s;
            resp.status = (slot < 0) ? ST_FULL : ST_ACCEPT;
            resp.fired_id = r.task_id;
            resp.fire_time = now_ticks;
            resp.last = 1'b1;
            if (slot >= 0) begin
               occupied[slot] = 1'b1;
               deadline[slot] = clamp_sum(now_ticks, r.delay);
               ident[slot] = r.task_id;
               recurring[slot] = r.is_recurring;
               interval[slot] = r.period;
            end
            owed_responses.push_back(resp);
            return;
         end
         // Advance time, then fire due tasks earliest first, lower slot on ties
         now_ticks = now_ticks + 32'd1;
         fired = '{default: 1'b0};
         n = 0;
         while (n < MAX_RESULTS) begin
            best = -1;
            for (int s = 0; s < DEPTH; s++)
               if (occupied[s] && !fired[s] && deadline[s] <= now_ticks)
                  if (best < 0 || deadline[s] < deadline[best]) best = s;
            if (best < 0) break;
            resp.status = ST_FIRED;
            resp.fired_id = ident[best];
            resp.fire_time = now_ticks;
            resp.last = 1'b0;
            owed_responses.push_back(resp);
            fired[best] = 1'b1;
            n++;
            if (recurring[best])
               deadline[best] = clamp_sum(now_ticks, interval[best]);
            else
               occupied[best] = 1'b0;
         end
         // Mark the final firing of this tick
         if (n > 0) begin
            resp = owed_responses.pop_back();
            resp.last = 1'b1;
            owed_responses.push_back(resp);
         end
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
         end
      endfunction

      // Compare one response against the oldest one owed
      function void check_result(rsp_type got);
         rsp_type want;
         if (owed_responses.size() == 0) begin
            $error("unexpected response: status %0d id 0x%0h", got.status, got.fired_id);
            errors++;
            return;
         end
         want = owed_responses.pop_front();
         compare_field("status", want.status, got.status);
         compare_field("fired_id", want.fired_id, got.fired_id);
         compare_field("fire_time", want.fire_time, got.fire_time);
         compare_field("last", want.last, got.last);
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_item;

   int cycle_count = 0;
   timer_queue_scoreboard sb;

   timer_event_priority_queue dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_item   (req_item),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Check every strobed response
   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_result(rsp_item);
   end

   function automatic req_type make_add(bit [7:0] id, bit [15:0] dly, bit rec, bit [15:0] per);
      req_type r;
      r.cmd = CMD_ADD;
      r.task_id = id;
      r.delay = dly;
      r.is_recurring = rec;
      r.period = per;
      return r;
   endfunction

   function automatic req_type make_tick();
      req_type r;
      r = '0;
      r.cmd = CMD_TICK;
      return r;
   endfunction

   // Mostly short delays and periods so tasks fire; make recurring tasks rare once 8 are resident
   function automatic req_type make_random_request();
      req_type r;
      int      rec_pct;
      r.cmd = ($urandom_range(0, 99) < 45) ? CMD_TICK : CMD_ADD;
      r.task_id = 8'($urandom_range(0, 255));
      r.delay = ($urandom_range(0, 99) < 3) ? 16'($urandom) : 16'($urandom_range(0, 12));
      rec_pct = (sb.resident_recurring() < 8) ? 30 : 3;
      r.is_recurring = ($urandom_range(0, 99) < rec_pct);
      r.period = ($urandom_range(0, 99) < 5) ? 16'($urandom) : 16'($urandom_range(0, 10));
      return r;
   endfunction

   // Present a request and hold it until the block takes it
   task automatic send_request(req_type r);
      @(negedge clock);
      start <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(r);
   endtask

   task automatic lower_start();
      @(negedge clock);
      start <= 1'b0;
   endtask

   // Idle the sender for a random number of cycles
   task automatic pause_sender(int pct);
      if ($urandom_range(0, 99) < pct) begin
         lower_start();
         while ($urandom_range(0, 99) < pct) @(negedge clock);
      end
   endtask

   // Hold off until every owed response has arrived
   task automatic wait_drained();
      lower_start();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin
      int idle_pct[3];
      sb = new;
      idle_pct = '{25, 48, 0};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Quiet tick, then a zero-delay one-shot
      send_request(make_tick());
      send_request(make_add(8'h00, 16'h0000, 1'b0, 16'h0000));
      send_request(make_tick());
      // Extreme delay and period; zero-period recurring; equal deadlines; earlier deadline
      send_request(make_add(8'hFF, 16'hFFFF, 1'b1, 16'hFFFF));
      send_request(make_add(8'h5A, 16'h0001, 1'b1, 16'h0000));
      send_request(make_add(8'hA5, 16'h0001, 1'b0, 16'hFFFF));
      send_request(make_add(8'h11, 16'h0001, 1'b0, 16'h1234));
      send_request(make_add(8'h22, 16'h0000, 1'b0, 16'h0000));
      send_request(make_tick());
      send_request(make_tick());
      // Fill the store, then overflow it once
      for (int k = 0; k < 14; k++)
         send_request(make_add(8'h30 + 8'(k), 16'd2, 1'b0, 16'(k)));
      send_request(make_add(8'hEE, 16'h0003, 1'b1, 16'h0002));
      wait_drained();

      // Random traffic: sender idling heavy, heavier, then none
      for (int phase = 0; phase < 3; phase++) begin
         for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            pause_sender(idle_pct[phase]);
            send_request(make_random_request());
         end
         wait_drained();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// File: sim.f
design/ttq_pkg.sv
design/ttq_cell.sv
design/ttq_ctrl.sv
design/timer_event_priority_queue.sv
design/ttq_checker.sv
bench/tb_timer_event_priority_queue.sv
